/* hw/rtl/vr3d_pkg.sv */
// Shared constants for the 3D vector reflection block.
package vr3d_pkg;
  localparam int VR3D_FRAC_BITS = 16;
  localparam int VR3D_WORD_BITS = 32;
  localparam int VR3D_LIMIT_BITS = 17;
  localparam logic [VR3D_LIMIT_BITS-1:0] VR3D_LIMIT_RESET = 17'd1;
endpackage

/* hw/rtl/vector_reflect_3d.sv */
// 3D vector reflection r = d - 2(d.n)n with optional normal normalization.
//
// Usage: drive dir_*, norm_* and normal_is_unit and raise start for one cycle
// per item. busy is always low: the block takes a new item every clock.
// Each item gives one result on refl_* with done high for one cycle.
// Throughput is one item per clock (default format Q16.16).
// The pipeline holds the square-root stages (one result bit per stage,
// WORD_BITS stages) and the reciprocal divider (one quotient bit per stage,
// 2*FRAC_BITS+1 stages), followed by the multiply and saturate stages.
// cfg_we writes cfg_wdata into the tiny magnitude limit; write it only while
// no item is in flight. Reset clears all valid bits, so items in flight are
// dropped and give no result afterward, and sets the limit to 1.
// The receiver cannot stall: results must be taken in the cycle shown.
module vector_reflect_3d
  import vr3d_pkg::*;
#(
  parameter int FRAC_BITS = VR3D_FRAC_BITS,
  parameter int WORD_BITS = VR3D_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_we,
  input  logic [VR3D_LIMIT_BITS-1:0]  cfg_wdata,
  input  logic signed [WORD_BITS-1:0] dir_x,
  input  logic signed [WORD_BITS-1:0] dir_y,
  input  logic signed [WORD_BITS-1:0] dir_z,
  input  logic signed [WORD_BITS-1:0] norm_x,
  input  logic signed [WORD_BITS-1:0] norm_y,
  input  logic signed [WORD_BITS-1:0] norm_z,
  input  logic                        normal_is_unit,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] refl_x,
  output logic signed [WORD_BITS-1:0] refl_y,
  output logic signed [WORD_BITS-1:0] refl_z
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int LB = VR3D_LIMIT_BITS;
  localparam int SW = 2 * W;
  localparam int QW = 2 * F + 1;
  localparam int NW = (W >= F + 2) ? W : F + 2;
  localparam int PW = W + QW + 1;
  localparam int LW = W + NW + 3;

  typedef struct packed {
    logic [2:0][W-1:0] d;
    logic [2:0][W-1:0] n;
    logic              unit;
    logic [LB-1:0]     lim;
  } item_t;

  function automatic logic [W-1:0] sat(input logic signed [LW-1:0] x);
    logic signed [LW-1:0] hi;
    logic signed [LW-1:0] lo;
    hi = LW'({1'b0, {(W-1){1'b1}}});
    lo = -hi - LW'(1);
    if (x > hi) begin
      return hi[W-1:0];
    end else if (x < lo) begin
      return lo[W-1:0];
    end
    return x[W-1:0];
  endfunction

  logic [LB-1:0] lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= VR3D_LIMIT_RESET;
    end else if (cfg_we) begin
      lim <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // input register
  logic  v0;
  item_t it0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    it0.d    <= {dir_z, dir_y, dir_x};
    it0.n    <= {norm_z, norm_y, norm_x};
    it0.unit <= normal_is_unit;
    it0.lim  <= lim;
  end

  // squares
  logic          v1;
  item_t         it1;
  logic [2:0][SW-1:0] sq1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    it1 <= it0;
    for (int i = 0; i < 3; i++) begin
      sq1[i] <= SW'($signed(it0.n[i]) * $signed(it0.n[i]));
    end
  end

  // sum of squares
  logic          v2;
  item_t         it2;
  logic [SW-1:0] sum2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    it2  <= it1;
    sum2 <= sq1[0] + sq1[1] + sq1[2];
  end

  // square root, one bit per stage
  logic          sv  [0:W];
  item_t         sit [0:W];
  logic [W-1:0]  srt [0:W];
  logic [SW+1:0] srm [0:W];

  assign sv[0]  = v2;
  assign sit[0] = it2;
  assign srt[0] = '0;
  assign srm[0] = (SW+2)'(sum2);

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    localparam int B = W - 1 - k;
    logic [SW+1:0] tr;
    assign tr = ((SW+2)'(srt[k]) << (B + 1)) + ((SW+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= sv[k];
      end
      sit[k+1] <= sit[k];
      if (srm[k] >= tr) begin
        srm[k+1] <= srm[k] - tr;
        srt[k+1] <= srt[k] | (W'(1) << B);
      end else begin
        srm[k+1] <= srm[k];
        srt[k+1] <= srt[k];
      end
    end
  end

  // tiny magnitude test
  logic         vz;
  item_t        itz;
  logic [W-1:0] magz;
  logic         zeroz;
  always_ff @(posedge clk) begin
    if (rst) begin
      vz <= 1'b0;
    end else begin
      vz <= sv[W];
    end
    itz   <= sit[W];
    magz  <= srt[W];
    zeroz <= (srt[W] == '0) ||
             ((W+LB)'(srt[W]) < (W+LB)'(sit[W].lim));
  end

  // reciprocal 2^(2F) / mag, one quotient bit per stage
  logic          dv  [0:QW];
  item_t         dit [0:QW];
  logic          dzr [0:QW];
  logic [W-1:0]  dmg [0:QW];
  logic [W-1:0]  drm [0:QW];
  logic [QW-1:0] dq  [0:QW];

  assign dv[0]  = vz;
  assign dit[0] = itz;
  assign dzr[0] = zeroz;
  assign dmg[0] = magz;
  assign drm[0] = '0;
  assign dq[0]  = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [W:0] tr;
    assign tr = {drm[k], (k == 0) ? 1'b1 : 1'b0};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      dit[k+1] <= dit[k];
      dzr[k+1] <= dzr[k];
      dmg[k+1] <= dmg[k];
      if (tr >= {1'b0, dmg[k]}) begin
        drm[k+1] <= W'(tr - {1'b0, dmg[k]});
        dq[k+1]  <= {dq[k][QW-2:0], 1'b1};
      end else begin
        drm[k+1] <= tr[W-1:0];
        dq[k+1]  <= {dq[k][QW-2:0], 1'b0};
      end
    end
  end

  // normalized normal
  logic                 vn;
  logic [2:0][W-1:0]    dn;
  logic signed [NW-1:0] nn [0:2];
  always_ff @(posedge clk) begin
    logic signed [PW-1:0] pr;
    if (rst) begin
      vn <= 1'b0;
    end else begin
      vn <= dv[QW];
    end
    dn <= dit[QW].d;
    for (int i = 0; i < 3; i++) begin
      pr = $signed(dit[QW].n[i]) * $signed({1'b0, dq[QW]});
      if (dit[QW].unit) begin
        nn[i] <= NW'($signed(dit[QW].n[i]));
      end else if (dzr[QW]) begin
        nn[i] <= '0;
      end else begin
        nn[i] <= NW'(pr >>> F);
      end
    end
  end

  // dot product terms
  logic                     vp;
  logic [2:0][W-1:0]        dp;
  logic signed [NW-1:0]     np [0:2];
  logic signed [W+NW-1:0]   pp [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else begin
      vp <= vn;
    end
    dp <= dn;
    for (int i = 0; i < 3; i++) begin
      np[i] <= nn[i];
      pp[i] <= $signed(dn[i]) * nn[i];
    end
  end

  // dot product sum
  logic                 vs;
  logic [2:0][W-1:0]    ds;
  logic signed [NW-1:0] ns [0:2];
  logic signed [LW-1:0] dsum;
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else begin
      vs <= vp;
    end
    ds   <= dp;
    ns   <= np;
    dsum <= LW'(pp[0]) + LW'(pp[1]) + LW'(pp[2]);
  end

  // scaled, saturated dot product
  logic                 vm;
  logic [2:0][W-1:0]    dm;
  logic signed [NW-1:0] nm [0:2];
  logic signed [W-1:0]  m;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= vs;
    end
    dm <= ds;
    nm <= ns;
    m  <= sat(dsum >>> F);
  end

  // m * n
  logic                   vt;
  logic [2:0][W-1:0]      dt;
  logic signed [W+NW-1:0] tt [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else begin
      vt <= vm;
    end
    dt <= dm;
    for (int i = 0; i < 3; i++) begin
      tt[i] <= m * nm[i];
    end
  end

  // d - 2mn, saturated
  logic [2:0][W-1:0] rr;
  always_ff @(posedge clk) begin
    logic signed [LW-1:0] t2;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vt;
    end
    for (int i = 0; i < 3; i++) begin
      t2 = (LW'(tt[i]) <<< 1) >>> F;
      rr[i] <= sat(LW'($signed(dt[i])) - t2);
    end
  end

  assign refl_x = rr[0];
  assign refl_y = rr[1];
  assign refl_z = rr[2];
endmodule

/* hw/rtl/vr3d_check.sv */
// Port-level checker for the 3D vector reflection block, with its bind.
module vr3d_check
  import vr3d_pkg::*;
#(
  parameter int FRAC_BITS = VR3D_FRAC_BITS,
  parameter int WORD_BITS = VR3D_WORD_BITS
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  localparam int LAT = 10 + WORD_BITS + 2 * FRAC_BITS + 1;

  a_result: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(LAT) done) else $error("item gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##(LAT) !done) else $error("result without item");

  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");

  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");
endmodule

bind vector_reflect_3d vr3d_check #(
  .FRAC_BITS(FRAC_BITS),
  .WORD_BITS(WORD_BITS)
) u_vr3d_check (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done)
);
